@@ src/shae_pkg.sv @@
`default_nettype none
package shae_pkg;

   localparam logic [2:0] MODE_SHA1   = 3'd0;
   localparam logic [2:0] MODE_SHA224 = 3'd1;
   localparam logic [2:0] MODE_SHA256 = 3'd2;
   localparam logic [2:0] MODE_SHA384 = 3'd3;
   localparam logic [2:0] MODE_SHA512 = 3'd4;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef logic [7:0][63:0] chain_type;

   // control from the sequencer to the compression unit
   typedef struct packed {
      logic        init;
      logic [2:0]  init_mode;
      logic        push;
      logic [63:0] push_word;
      logic        start;
   } core_ctl_type;

   typedef enum logic [1:0] {ST_IDLE, ST_PAD, ST_COMP, ST_EMIT} state_type;
   typedef enum logic [1:0] {CORE_IDLE, CORE_RUN, CORE_ADD} core_state_type;

   function automatic logic is_wide(input logic [2:0] mode);
      return (mode == MODE_SHA384) || (mode == MODE_SHA512);
   endfunction

   function automatic logic [3:0] word_count(input logic [2:0] mode);
      case (mode)
         MODE_SHA1:   return 4'd5;
         MODE_SHA224: return 4'd7;
         MODE_SHA384: return 4'd6;
         default:     return 4'd8;
      endcase
   endfunction

   function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
      if (rnd < 7'd20)      return 32'h5A827999;
      else if (rnd < 7'd40) return 32'h6ED9EBA1;
      else if (rnd < 7'd60) return 32'h8F1BBCDC;
      else                  return 32'hCA62C1D6;
   endfunction

   // SHA-256 round constants are the upper halves of these
   function automatic logic [63:0] k512(input logic [6:0] rnd);
      case (rnd)
         7'd0:  return 64'h428a2f98d728ae22;  7'd1:  return 64'h7137449123ef65cd;
         7'd2:  return 64'hb5c0fbcfec4d3b2f;  7'd3:  return 64'he9b5dba58189dbbc;
         7'd4:  return 64'h3956c25bf348b538;  7'd5:  return 64'h59f111f1b605d019;
         7'd6:  return 64'h923f82a4af194f9b;  7'd7:  return 64'hab1c5ed5da6d8118;
         7'd8:  return 64'hd807aa98a3030242;  7'd9:  return 64'h12835b0145706fbe;
         7'd10: return 64'h243185be4ee4b28c;  7'd11: return 64'h550c7dc3d5ffb4e2;
         7'd12: return 64'h72be5d74f27b896f;  7'd13: return 64'h80deb1fe3b1696b1;
         7'd14: return 64'h9bdc06a725c71235;  7'd15: return 64'hc19bf174cf692694;
         7'd16: return 64'he49b69c19ef14ad2;  7'd17: return 64'hefbe4786384f25e3;
         7'd18: return 64'h0fc19dc68b8cd5b5;  7'd19: return 64'h240ca1cc77ac9c65;
         7'd20: return 64'h2de92c6f592b0275;  7'd21: return 64'h4a7484aa6ea6e483;
         7'd22: return 64'h5cb0a9dcbd41fbd4;  7'd23: return 64'h76f988da831153b5;
         7'd24: return 64'h983e5152ee66dfab;  7'd25: return 64'ha831c66d2db43210;
         7'd26: return 64'hb00327c898fb213f;  7'd27: return 64'hbf597fc7beef0ee4;
         7'd28: return 64'hc6e00bf33da88fc2;  7'd29: return 64'hd5a79147930aa725;
         7'd30: return 64'h06ca6351e003826f;  7'd31: return 64'h142929670a0e6e70;
         7'd32: return 64'h27b70a8546d22ffc;  7'd33: return 64'h2e1b21385c26c926;
         7'd34: return 64'h4d2c6dfc5ac42aed;  7'd35: return 64'h53380d139d95b3df;
         7'd36: return 64'h650a73548baf63de;  7'd37: return 64'h766a0abb3c77b2a8;
         7'd38: return 64'h81c2c92e47edaee6;  7'd39: return 64'h92722c851482353b;
         7'd40: return 64'ha2bfe8a14cf10364;  7'd41: return 64'ha81a664bbc423001;
         7'd42: return 64'hc24b8b70d0f89791;  7'd43: return 64'hc76c51a30654be30;
         7'd44: return 64'hd192e819d6ef5218;  7'd45: return 64'hd69906245565a910;
         7'd46: return 64'hf40e35855771202a;  7'd47: return 64'h106aa07032bbd1b8;
         7'd48: return 64'h19a4c116b8d2d0c8;  7'd49: return 64'h1e376c085141ab53;
         7'd50: return 64'h2748774cdf8eeb99;  7'd51: return 64'h34b0bcb5e19b48a8;
         7'd52: return 64'h391c0cb3c5c95a63;  7'd53: return 64'h4ed8aa4ae3418acb;
         7'd54: return 64'h5b9cca4f7763e373;  7'd55: return 64'h682e6ff3d6b2b8a3;
         7'd56: return 64'h748f82ee5defb2fc;  7'd57: return 64'h78a5636f43172f60;
         7'd58: return 64'h84c87814a1f0ab72;  7'd59: return 64'h8cc702081a6439ec;
         7'd60: return 64'h90befffa23631e28;  7'd61: return 64'ha4506cebde82bde9;
         7'd62: return 64'hbef9a3f7b2c67915;  7'd63: return 64'hc67178f2e372532b;
         7'd64: return 64'hca273eceea26619c;  7'd65: return 64'hd186b8c721c0c207;
         7'd66: return 64'heada7dd6cde0eb1e;  7'd67: return 64'hf57d4f7fee6ed178;
         7'd68: return 64'h06f067aa72176fba;  7'd69: return 64'h0a637dc5a2c898a6;
         7'd70: return 64'h113f9804bef90dae;  7'd71: return 64'h1b710b35131c471b;
         7'd72: return 64'h28db77f523047d84;  7'd73: return 64'h32caab7b40c72493;
         7'd74: return 64'h3c9ebe0a15c9bebc;  7'd75: return 64'h431d67c49c100d4c;
         7'd76: return 64'h4cc5d4becb3e42b6;  7'd77: return 64'h597f299cfc657e2a;
         7'd78: return 64'h5fcb6fab3ad6faec;  7'd79: return 64'h6c44198c4a475817;
         default: return 64'h0;
      endcase
   endfunction

   function automatic logic [63:0] iv384(input logic [2:0] idx);
      case (idx)
         3'd0: return 64'hcbbb9d5dc1059ed8;  3'd1: return 64'h629a292a367cd507;
         3'd2: return 64'h9159015a3070dd17;  3'd3: return 64'h152fecd8f70e5939;
         3'd4: return 64'h67332667ffc00b31;  3'd5: return 64'h8eb44a8768581511;
         3'd6: return 64'hdb0c2e0d64f98fa7;  default: return 64'h47b5481dbefa4fa4;
      endcase
   endfunction

   function automatic logic [63:0] iv512(input logic [2:0] idx);
      case (idx)
         3'd0: return 64'h6a09e667f3bcc908;  3'd1: return 64'hbb67ae8584caa73b;
         3'd2: return 64'h3c6ef372fe94f82b;  3'd3: return 64'ha54ff53a5f1d36f1;
         3'd4: return 64'h510e527fade682d1;  3'd5: return 64'h9b05688c2b3e6c1f;
         3'd6: return 64'h1f83d9abfb41bd6b;  default: return 64'h5be0cd19137e2179;
      endcase
   endfunction

   function automatic logic [31:0] iv_sha1(input logic [2:0] idx);
      case (idx)
         3'd0: return 32'h67452301;  3'd1: return 32'hEFCDAB89;
         3'd2: return 32'h98BADCFE;  3'd3: return 32'h10325476;
         3'd4: return 32'hC3D2E1F0;  default: return 32'h0;
      endcase
   endfunction

   // SHA-224 uses the low halves of the SHA-384 values, SHA-256 the high
   // halves of the SHA-512 values
   function automatic logic [63:0] iv_word(input logic [2:0] mode, input logic [2:0] idx);
      logic [63:0] w384;
      logic [63:0] w512;
      w384 = iv384(idx);
      w512 = iv512(idx);
      case (mode)
         MODE_SHA1:   return {32'h0, iv_sha1(idx)};
         MODE_SHA224: return {32'h0, w384[31:0]};
         MODE_SHA384: return w384;
         MODE_SHA512: return w512;
         default:     return {32'h0, w512[63:32]};
      endcase
   endfunction

   function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [63:0] rotr64(input logic [63:0] x, input int n);
      return (x >> n) | (x << (64 - n));
   endfunction

endpackage
`default_nettype wire

@@ src/sha_multi_mode_hash_engine.sv @@
`default_nettype none
// Multi-mode SHA engine (SHA-1/224/256/384/512). Message bytes enter one per
// word on req (kind 0); kind 1 pads the message, appends its 64-bit bit count
// and returns the digest on rsp as 5, 7, 8, 6 or 8 words, big-endian order,
// 32-bit modes in the low half. The engine then re-initializes for the
// current mode. Bytes are taken one per cycle while idle; the byte that
// fills a block (64 bytes, or 128 in SHA-384/512) also starts the
// compression in one shared round unit at one round per cycle, and req
// stays stalled until it is done. Finish pushes padding one byte per cycle
// (up to one block plus the next), compresses once or twice, then presents
// one digest word per cycle while rsp is not stalled.
// req_stall is high whenever the engine is busy or a csr write is offered.
// hash_mode (csr_data) is
// written only while idle; values 5 to 7 are dropped; a write resets the
// message state. Reset mode is SHA-256.
module sha_multi_mode_hash_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire shae_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output shae_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [2:0]        csr_data
);
   import shae_pkg::*;

   state_type    state_ff, state_in;
   logic [2:0]   mode_ff, mode_in;
   logic [7:0]   fill_ff, fill_in;
   logic [63:0]  mbits_ff, mbits_in;
   logic [63:0]  acc_ff, acc_in;
   logic         first_ff, first_in;     // next pad byte is 0x80
   logic         second_ff, second_in;   // current block has no room for the count
   logic         pad_ff, pad_in;         // inside a finish sequence
   logic         final_ff, final_in;     // running compression is the last one
   logic [2:0]   idx_ff, idx_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;

   core_ctl_type ctl;
   logic         core_done;
   chain_type    chain;

   logic         wide;
   logic [7:0]   blk_size, len_pos, fill_inc;
   logic         byte_en;
   logic [7:0]   byte_val;
   logic [63:0]  new_acc;
   logic         word_end, block_end;
   logic         req_take, csr_take, rsp_free, last_idx;

   assign wide      = is_wide(mode_ff);
   assign blk_size  = wide ? 8'd128 : 8'd64;
   assign len_pos   = blk_size - 8'd8;
   assign fill_inc  = fill_ff + 8'd1;
   assign new_acc   = {acc_ff[55:0], byte_val};
   assign word_end  = wide ? (fill_inc[2:0] == 3'd0) : (fill_inc[1:0] == 2'd0);
   assign block_end = (fill_inc == blk_size);

   // a pending csr write holds off req so no word is taken and dropped
   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_take  = csr_valid && csr_ready;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign last_idx  = ({1'b0, idx_ff} + 4'd1 == word_count(mode_ff));

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      fill_in      = fill_ff;
      mbits_in     = mbits_ff;
      acc_in       = acc_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      pad_in       = pad_ff;
      final_in     = final_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      byte_en      = 1'b0;
      byte_val     = 8'h00;
      ctl          = '0;
      ctl.init_mode = mode_ff;

      case (state_ff)
         ST_IDLE: begin
            if (csr_take && (csr_data <= MODE_SHA512)) begin
               mode_in       = csr_data;
               ctl.init      = 1'b1;
               ctl.init_mode = csr_data;
               fill_in       = 8'd0;
               mbits_in      = 64'd0;
            end else if (req_take) begin
               if (req_data.kind) begin
                  pad_in   = 1'b1;
                  first_in = 1'b1;
                  state_in = ST_PAD;
               end else begin
                  byte_en  = 1'b1;
                  byte_val = req_data.data_byte;
                  mbits_in = mbits_ff + 64'd8;
               end
            end
         end
         ST_PAD: begin
            byte_en = 1'b1;
            if (first_ff) begin
               byte_val  = PAD_BYTE;
               first_in  = 1'b0;
               second_in = (fill_ff >= len_pos);
            end else if ((fill_ff >= len_pos) && !second_ff) begin
               byte_val = mbits_ff[63:56];
               mbits_in = {mbits_ff[55:0], 8'h00};
            end
         end
         ST_COMP: begin
            if (core_done) begin
               if (!pad_ff) begin
                  state_in = ST_IDLE;
               end else if (final_ff) begin
                  idx_in   = 3'd0;
                  state_in = ST_EMIT;
               end else begin
                  second_in = 1'b0;
                  state_in  = ST_PAD;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.digest_word  = chain[idx_ff];
               rsp_in.word_index   = idx_ff;
               rsp_in.last_word    = last_idx;
               idx_in              = idx_ff + 3'd1;
               if (last_idx) begin
                  ctl.init = 1'b1;
                  fill_in  = 8'd0;
                  mbits_in = 64'd0;
                  pad_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // shared byte path into the block window
      if (byte_en) begin
         acc_in  = new_acc;
         fill_in = fill_inc;
         if (word_end) begin
            ctl.push      = 1'b1;
            ctl.push_word = wide ? new_acc : {32'h0, new_acc[31:0]};
         end
         if (block_end) begin
            fill_in   = 8'd0;
            ctl.start = 1'b1;
            final_in  = pad_ff && !second_in;
            state_in  = ST_COMP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_SHA256;
         fill_ff      <= 8'd0;
         mbits_ff     <= 64'd0;
         first_ff     <= 1'b0;
         second_ff    <= 1'b0;
         pad_ff       <= 1'b0;
         final_ff     <= 1'b0;
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         fill_ff      <= fill_in;
         mbits_ff     <= mbits_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         pad_ff       <= pad_in;
         final_ff     <= final_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff <= acc_in;
      rsp_ff <= rsp_in;
   end

   shae_core u_core (
      .clock (clock),
      .reset (reset),
      .mode  (mode_ff),
      .ctl   (ctl),
      .done  (core_done),
      .chain (chain)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

@@ src/shae_core.sv @@
`default_nettype none
module shae_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [2:0]            mode,
   input  wire shae_pkg::core_ctl_type ctl,
   output logic                       done,
   output shae_pkg::chain_type        chain
);
   import shae_pkg::*;

   core_state_type  state_ff, state_in;
   logic [6:0]      rnd_ff, rnd_in;
   chain_type       chain_ff, chain_in;
   logic [7:0][63:0] s_ff, s_in;
   logic [15:0][63:0] win_ff, win_in;

   logic        wide, sha1;
   logic [6:0]  last_rnd;
   logic [63:0] sched_new;
   logic [7:0][63:0] s_next;

   logic [31:0] a32, b32, c32, d32, e32, f32, g32, h32, w32, t1_32, t2_32, fn32;
   logic [31:0] x1_32, x14_32;
   logic [63:0] t1_64, t2_64, x1_64, x14_64, k64;

   assign wide     = is_wide(mode);
   assign sha1     = (mode == MODE_SHA1);
   assign last_rnd = (wide || sha1) ? 7'd79 : 7'd63;
   assign k64      = k512(rnd_ff);

   // message schedule: window is w[t]..w[t+15]
   always_comb begin
      x1_32  = win_ff[1][31:0];
      x14_32 = win_ff[14][31:0];
      x1_64  = win_ff[1];
      x14_64 = win_ff[14];
      if (sha1) begin
         sched_new = {32'h0, rotr32(win_ff[13][31:0] ^ win_ff[8][31:0] ^ win_ff[2][31:0]
                                    ^ win_ff[0][31:0], 31)};
      end else if (wide) begin
         sched_new = (rotr64(x14_64, 19) ^ rotr64(x14_64, 61) ^ (x14_64 >> 6)) + win_ff[9]
                   + (rotr64(x1_64, 1) ^ rotr64(x1_64, 8) ^ (x1_64 >> 7)) + win_ff[0];
      end else begin
         sched_new = {32'h0, (rotr32(x14_32, 17) ^ rotr32(x14_32, 19) ^ (x14_32 >> 10))
                   + win_ff[9][31:0] + (rotr32(x1_32, 7) ^ rotr32(x1_32, 18) ^ (x1_32 >> 3))
                   + win_ff[0][31:0]};
      end
   end

   // one round
   always_comb begin
      a32 = s_ff[0][31:0]; b32 = s_ff[1][31:0]; c32 = s_ff[2][31:0]; d32 = s_ff[3][31:0];
      e32 = s_ff[4][31:0]; f32 = s_ff[5][31:0]; g32 = s_ff[6][31:0]; h32 = s_ff[7][31:0];
      w32 = win_ff[0][31:0];
      s_next = s_ff;
      fn32  = 32'h0;
      t1_32 = 32'h0;
      t2_32 = 32'h0;
      t1_64 = 64'h0;
      t2_64 = 64'h0;
      if (sha1) begin
         if (rnd_ff < 7'd20)      fn32 = (b32 & c32) ^ (~b32 & d32);
         else if (rnd_ff < 7'd40) fn32 = b32 ^ c32 ^ d32;
         else if (rnd_ff < 7'd60) fn32 = (b32 & c32) ^ (b32 & d32) ^ (c32 & d32);
         else                     fn32 = b32 ^ c32 ^ d32;
         t1_32 = rotr32(a32, 27) + fn32 + e32 + sha1_k(rnd_ff) + w32;
         s_next[0] = {32'h0, t1_32};
         s_next[1] = {32'h0, a32};
         s_next[2] = {32'h0, rotr32(b32, 2)};
         s_next[3] = {32'h0, c32};
         s_next[4] = {32'h0, d32};
      end else if (wide) begin
         t1_64 = s_ff[7] + (rotr64(s_ff[4], 14) ^ rotr64(s_ff[4], 18) ^ rotr64(s_ff[4], 41))
               + ((s_ff[4] & s_ff[5]) ^ (~s_ff[4] & s_ff[6])) + k64 + win_ff[0];
         t2_64 = (rotr64(s_ff[0], 28) ^ rotr64(s_ff[0], 34) ^ rotr64(s_ff[0], 39))
               + ((s_ff[0] & s_ff[1]) ^ (s_ff[0] & s_ff[2]) ^ (s_ff[1] & s_ff[2]));
         s_next = {s_ff[6], s_ff[5], s_ff[4], s_ff[3] + t1_64,
                   s_ff[2], s_ff[1], s_ff[0], t1_64 + t2_64};
      end else begin
         t1_32 = h32 + (rotr32(e32, 6) ^ rotr32(e32, 11) ^ rotr32(e32, 25))
               + ((e32 & f32) ^ (~e32 & g32)) + k64[63:32] + w32;
         t2_32 = (rotr32(a32, 2) ^ rotr32(a32, 13) ^ rotr32(a32, 22))
               + ((a32 & b32) ^ (a32 & c32) ^ (b32 & c32));
         s_next = {{32'h0, g32}, {32'h0, f32}, {32'h0, e32}, {32'h0, d32 + t1_32},
                   {32'h0, c32}, {32'h0, b32}, {32'h0, a32}, {32'h0, t1_32 + t2_32}};
      end
   end

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      chain_in = chain_ff;
      s_in     = s_ff;
      win_in   = win_ff;
      done     = 1'b0;
      case (state_ff)
         CORE_IDLE: begin
            if (ctl.init) begin
               for (int i = 0; i < 8; i++) chain_in[i] = iv_word(ctl.init_mode, 3'(i));
            end
            if (ctl.push) win_in = {ctl.push_word, win_ff[15:1]};
            if (ctl.start) begin
               s_in     = chain_ff;
               rnd_in   = 7'd0;
               state_in = CORE_RUN;
            end
         end
         CORE_RUN: begin
            s_in   = s_next;
            win_in = {sched_new, win_ff[15:1]};
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == last_rnd) state_in = CORE_ADD;
         end
         CORE_ADD: begin
            for (int i = 0; i < 8; i++) begin
               if (wide) chain_in[i] = chain_ff[i] + s_ff[i];
               else      chain_in[i] = {32'h0, chain_ff[i][31:0] + s_ff[i][31:0]};
            end
            done     = 1'b1;
            state_in = CORE_IDLE;
         end
         default: state_in = CORE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORE_IDLE;
         rnd_ff   <= 7'd0;
         for (int i = 0; i < 8; i++) chain_ff[i] <= iv_word(MODE_SHA256, 3'(i));
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         chain_ff <= chain_in;
      end
      s_ff   <= s_in;
      win_ff <= win_in;
   end

   assign chain = chain_ff;

endmodule
`default_nettype wire
